// ===== rtl/aes_pkg.sv =====
// aes_pkg: shared types, S-box table and round functions for the AES-128 core.
// Used by aes_key_sched and aes128_block_encrypt_core; depends on nothing.
package aes_pkg;

   localparam int AES_FULL_ROUNDS = 9;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } rsp_type;

   typedef struct packed {
      logic busy;
   } ks_status_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte n of the block sits in bits 127-8n down to 120-8n.
   function automatic logic [7:0] get_byte(input logic [127:0] s, input int n);
      return s[127 - 8*n -: 8];
   endfunction

   // One cipher round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey.
   function automatic logic [127:0] round_fn(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic         final_rnd);
      logic [7:0]   t [16];
      logic [7:0]   m [16];
      logic [7:0]   a0, a1, a2, a3, d0, d1, d2, d3;
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c + r] = SBOX[get_byte(s, 4*((c + r) % 4) + r)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4*c];
         a1 = t[4*c + 1];
         a2 = t[4*c + 2];
         a3 = t[4*c + 3];
         d0 = xtime(a0);
         d1 = xtime(a1);
         d2 = xtime(a2);
         d3 = xtime(a3);
         m[4*c]     = d0 ^ d1 ^ a1 ^ a2 ^ a3;
         m[4*c + 1] = a0 ^ d1 ^ d2 ^ a2 ^ a3;
         m[4*c + 2] = a0 ^ a1 ^ d2 ^ d3 ^ a3;
         m[4*c + 3] = d0 ^ a0 ^ a1 ^ a2 ^ d3;
      end
      for (int n = 0; n < 16; n++) begin
         o[127 - 8*n -: 8] = (final_rnd ? t[n] : m[n]) ^ get_byte(rk, n);
      end
      return o;
   endfunction

   // Next round key from the previous one.
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rcon);
      logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      n0 = w0 ^ t;
      n1 = w1 ^ n0;
      n2 = w2 ^ n1;
      n3 = w3 ^ n2;
      return {n0, n1, n2, n3};
   endfunction

endpackage

// ===== rtl/aes_key_sched.sv =====
// aes_key_sched: expands the cipher key into the round keys, one key per cycle.
// Depends on aes_pkg (S-box, next_key, xtime, status type).
module aes_key_sched #(
   parameter int FULL_ROUNDS = aes_pkg::AES_FULL_ROUNDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [127:0]          cipher_key,
   output logic [127:0]          round_keys [FULL_ROUNDS + 2],
   output aes_pkg::ks_status_type status
);

   localparam int NumKeys = FULL_ROUNDS + 2;
   localparam int CntW    = $clog2(NumKeys);

   logic [127:0]    rk_ff [NumKeys];
   logic [127:0]    cur_ff;
   logic [127:0]    cur_in;
   logic [7:0]      rcon_ff;
   logic [CntW-1:0] rnd_ff;
   logic            busy_ff;

   assign cur_in = aes_pkg::next_key(cur_ff, rcon_ff);

   // Round 0 loads the raw key; the following rounds each derive one key.
   always_ff @(posedge clock) begin
      if (reset || start) begin
         busy_ff <= 1'b1;
         rnd_ff  <= '0;
      end else if (busy_ff) begin
         if (rnd_ff == '0) begin
            rk_ff[0] <= cipher_key;
            cur_ff   <= cipher_key;
            rcon_ff  <= 8'h01;
            rnd_ff   <= CntW'(1);
         end else begin
            rk_ff[rnd_ff] <= cur_in;
            cur_ff        <= cur_in;
            rcon_ff       <= aes_pkg::xtime(rcon_ff);
            if (rnd_ff == CntW'(NumKeys - 1)) begin
               busy_ff <= 1'b0;
            end else begin
               rnd_ff <= rnd_ff + CntW'(1);
            end
         end
      end
   end

   assign round_keys  = rk_ff;
   assign status.busy = busy_ff;

endmodule

// ===== rtl/aes128_block_encrypt_core.sv =====
// aes128_block_encrypt_core: pipelined AES-128 ECB encryption, one block per stage.
// Depends on aes_pkg and aes_key_sched.
//
//   channel   ports                                 direction
//   req       req_valid, req_stall, req_data        block in
//   rsp       rsp_valid, rsp_stall, rsp_data        ciphertext out
//   csr       psel, penable, pwrite, paddr, ...     key_high at 0x0, key_low at 0x8
//
// One block enters per cycle while req_stall is low; the pipeline holds the initial key
// add, then one stage per round. After reset and after each key write the key
// schedule runs, and req_stall is high while it is busy.
// Stages advance independently: a bubble fills while the output is stalled.
module aes128_block_encrypt_core #(
   parameter int FULL_ROUNDS = aes_pkg::AES_FULL_ROUNDS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aes_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aes_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [3:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   localparam int NumStages = FULL_ROUNDS + 2;

   localparam logic [3:0] AddrKeyHigh = 4'h0;
   localparam logic [3:0] AddrKeyLow  = 4'h8;

   logic [63:0]            key_high_ff;
   logic [63:0]            key_low_ff;
   logic                   csr_wr;
   logic                   key_wr;
   logic [127:0]           round_keys [NumStages];
   aes_pkg::ks_status_type ks_status;

   logic [127:0]           st_ff    [NumStages];
   logic                   valid_ff [NumStages];
   logic                   adv      [NumStages + 1];
   logic                   req_xfer;

   // Configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign key_wr = csr_wr && (paddr == AddrKeyHigh || paddr == AddrKeyLow);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_wr) begin
         case (paddr)
            AddrKeyHigh: key_high_ff <= pwdata;
            AddrKeyLow:  key_low_ff  <= pwdata;
            default:     ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         AddrKeyHigh: prdata = key_high_ff;
         AddrKeyLow:  prdata = key_low_ff;
         default:     prdata = '0;
      endcase
   end

   aes_key_sched #(
      .FULL_ROUNDS (FULL_ROUNDS)
   ) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (key_wr),
      .cipher_key ({key_high_ff, key_low_ff}),
      .round_keys (round_keys),
      .status     (ks_status)
   );

   // A stage advances when it is empty or its successor advances.
   always_comb begin
      adv[NumStages] = !rsp_stall;
      for (int i = NumStages - 1; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i + 1];
      end
   end

   assign req_stall = !adv[0] || ks_status.busy;
   assign req_xfer  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumStages; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_xfer;
         end
         for (int i = 1; i < NumStages; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st_ff[0] <= {req_data.block_high, req_data.block_low} ^ round_keys[0];
      end
      for (int i = 1; i < NumStages; i++) begin
         if (adv[i]) begin
            st_ff[i] <= aes_pkg::round_fn(st_ff[i - 1], round_keys[i], i == NumStages - 1);
         end
      end
   end

   assign rsp_valid            = valid_ff[NumStages - 1];
   assign rsp_data.cipher_high = st_ff[NumStages - 1][127:64];
   assign rsp_data.cipher_low  = st_ff[NumStages - 1][63:0];

endmodule

// ===== dv/tb_aes128_block_encrypt_core.sv =====
// Testbench for the AES-128 ECB encryption core: random and directed blocks under
// several keys, checked against an in-bench AES-128 encryptor. Depends on aes_pkg.
`timescale 1ns / 1ps

module tb_aes128_block_encrypt_core;

   localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
   localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;
   localparam int         PIPE_DEPTH    = 11;
   localparam int         CYCLE_LIMIT   = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   aes_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   aes_pkg::rsp_type rsp_data;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [3:0]       paddr = '0;
   logic [63:0]      pwdata = '0;
   logic [63:0]      prdata;
   logic             pready;

   aes128_block_encrypt_core dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state: key registers and expanded round keys.
   logic [63:0]  key_hi_reg, key_lo_reg;
   logic [127:0] round_keys [11];
   logic [7:0]   sbox_tab [256];

   aes_pkg::req_type plain_queue [$];
   aes_pkg::rsp_type cipher_queue [$];
   int      mismatches, checked, cycles;
   int      blocks_sent;

   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = gf_double(a);
      end
      return p;
   endfunction

   // Inverse in GF(2^8) then the affine map.
   function automatic logic [7:0] sbox_calc(input logic [7:0] x);
      logic [7:0] r, b;
      r = 8'h01;
      b = x;
      for (int e = 0; e < 8; e++) begin
         if (e != 0) r = gf_mul(r, b);
         b = gf_mul(b, b);
      end
      return r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]}
             ^ 8'h63;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      {w[0], w[1], w[2], w[3]} = {key_hi_reg, key_lo_reg};
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {sbox_tab[t[23:16]] ^ rc, sbox_tab[t[15:8]], sbox_tab[t[7:0]],
                 sbox_tab[t[31:24]]};
            rc = gf_double(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int k = 0; k < 11; k++) round_keys[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
   endfunction

   function automatic aes_pkg::rsp_type encrypt_block(input aes_pkg::req_type p);
      logic [7:0]       s [16];
      logic [7:0]       t [16];
      logic [7:0]       a0, a1, a2, a3;
      logic [127:0]     v;
      aes_pkg::rsp_type o;
      v = {p.block_high, p.block_low} ^ round_keys[0];
      for (int n = 0; n < 16; n++) s[n] = v[127-8*n -: 8];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[4*c+r] = sbox_tab[s[4*((c+r)%4)+r]];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (rnd != 10) begin
               s[4*c]   = gf_double(a0 ^ a1) ^ a1 ^ a2 ^ a3;
               s[4*c+1] = gf_double(a1 ^ a2) ^ a0 ^ a2 ^ a3;
               s[4*c+2] = gf_double(a2 ^ a3) ^ a0 ^ a1 ^ a3;
               s[4*c+3] = gf_double(a3 ^ a0) ^ a0 ^ a1 ^ a2;
            end else begin
               s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
            end
         end
         for (int n = 0; n < 16; n++) s[n] ^= round_keys[rnd][127-8*n -: 8];
      end
      for (int n = 0; n < 16; n++) v[127-8*n -: 8] = s[n];
      o.cipher_high = v[127:64];
      o.cipher_low  = v[63:0];
      return o;
   endfunction

   // Driver: hold each block for a random gap, then present until transfer.
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            cipher_queue.push_back(encrypt_block(req_data));
            blocks_sent++;
            void'(plain_queue.pop_front());
            send_gap = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 12);
            if (send_gap == 0 && plain_queue.size() != 0) begin
               req_data <= plain_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (plain_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= plain_queue[0];
            end
         end
      end
   end

   // Monitor: random stall, compare each transfer with the oldest prediction.
   int stall_left = 0;
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (cipher_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected ciphertext: expected none got %h", rsp_data);
            end else begin
               aes_pkg::rsp_type want;
               want = cipher_queue.pop_front();
               checked++;
               if (rsp_data.cipher_high !== want.cipher_high ||
                   rsp_data.cipher_low !== want.cipher_low) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ciphertext mismatch: expected %h_%h got %h_%h",
                              want.cipher_high, want.cipher_low,
                              rsp_data.cipher_high, rsp_data.cipher_low);
               end
            end
            stall_left = (($urandom % 4) == 0) ? 0 : $urandom_range(0, 12);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_key_reg(input logic [3:0] addr, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_KEY_HIGH) key_hi_reg = value;
      else key_lo_reg = value;
      expand_round_keys();
   endtask

   task automatic drain_blocks();
      while (plain_queue.size() != 0 || cipher_queue.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo);
      aes_pkg::req_type p;
      p.block_high = hi;
      p.block_low  = lo;
      plain_queue.push_back(p);
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom % 8)
            0: queue_block('0, rand64());
            1: queue_block('1, rand64());
            2: queue_block(rand64(), {2'($urandom), 62'h0});
            default: queue_block(rand64(), rand64());
         endcase
      end
      drain_blocks();
   endtask

   initial begin
      for (int i = 0; i < 256; i++) sbox_tab[i] = sbox_calc(i[7:0]);
      key_hi_reg = '0;
      key_lo_reg = '0;
      expand_round_keys();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Zero key from reset, extremes of the block.
      queue_block('0, '0);
      queue_block('1, '1);
      queue_block('0, '1);
      queue_block('1, '0);
      queue_block(64'h8000000000000000, 64'h0000000000000001);
      drain_blocks();

      // Key with the FIPS-197 low half and an altered high half, with a half-updated key between the two writes.
      write_key_reg(ADDR_KEY_HIGH, 64'h000102030405060f ^ 64'h000000000000000e);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      drain_blocks();
      write_key_reg(ADDR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      drain_blocks();
      write_key_reg(ADDR_KEY_HIGH, 64'h2b7e151628aed2a6);
      write_key_reg(ADDR_KEY_LOW, 64'habf7158809cf4f3c);
      queue_block(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      queue_block('1, '1);
      drain_blocks();

      write_key_reg(ADDR_KEY_HIGH, '1);
      write_key_reg(ADDR_KEY_LOW, '1);
      random_phase(250);
      write_key_reg(ADDR_KEY_HIGH, '0);
      write_key_reg(ADDR_KEY_LOW, '0);
      random_phase(250);
      for (int ph = 0; ph < 4; ph++) begin
         write_key_reg(ADDR_KEY_HIGH, rand64());
         write_key_reg(ADDR_KEY_LOW, rand64());
         random_phase(210);
      end

      $display("encrypted %0d blocks under zero, all-ones, standard and random keys",
               blocks_sent);
      $display("checked %0d ciphertexts, %0d mismatches", checked, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
